/* hdl/gcli_pkg.sv */
// Shared types, constants and command/status structs for the grid interpolation unit.
`default_nettype none

package gcli_pkg;

    // Configuration defaults
    localparam int MAX_NODES_DEF = 4096;
    localparam int CORNERS       = 4;
    localparam int CIDX_W        = $clog2(CORNERS);
    localparam int K_W           = $clog2(CORNERS + 1);

    // Field widths
    localparam int ACTION_W   = 2;
    localparam int COORD_W    = 32;
    localparam int VALUE_W    = 32;
    localparam int SPACE_W    = 31;
    localparam int COUNT_W    = 13;
    localparam int CELL_W     = 12;
    localparam int FRAC_W     = 16;
    localparam int WGT_W      = 17;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int MA_W       = 33;
    localparam int MB_W       = 18;
    localparam int PROD_W     = MA_W + MB_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int QUO_W      = COORD_W + FRAC_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [WGT_W-1:0] ONE_Q16    = 17'h10000;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOCATE  = 2'd0,
        ACT_QUALIFY = 2'd1,
        ACT_INTERP  = 2'd2,
        ACT_NOP     = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_SPACE_X  = 3'd2,
        CFG_SPACE_Y  = 3'd3,
        CFG_COUNT_X  = 3'd4,
        CFG_COUNT_Y  = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MS_IDLE  = 3'd0,
        MS_EXT_X = 3'd1,
        MS_EXT_Y = 3'd2,
        MS_WGT   = 3'd3,
        MS_VAL   = 3'd4
    } mul_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXT_X,
        S_EXT_Y,
        S_CHK,
        S_DIVX_GO,
        S_DIVX_WAIT,
        S_DIVY_GO,
        S_DIVY_WAIT,
        S_WGT,
        S_ACC,
        S_FIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              capture;
        logic              qualify;
        logic              set_null;
        logic              chk_x;
        logic              chk_xy;
        logic              div_start;
        logic              div_axis_y;
        logic              div_store;
        mul_sel_t          mul_sel;
        logic [CIDX_W-1:0] mul_idx;
        logic              wgt_wr;
        logic [CIDX_W-1:0] wgt_idx;
        logic              acc_add;
        logic              fin;
        logic              out_load;
    } gcli_cmd_t;

    typedef struct packed {
        logic loc_ok;
        logic null_now;
        logic div_done;
        logic out_free;
    } gcli_sts_t;

endpackage

`default_nettype wire

/* hdl/gcli_div.sv */
// Restoring divider, one quotient bit per cycle, for cell index and fraction.
`default_nettype none

module gcli_div import gcli_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [COORD_W-1:0] dividend,
    input  wire logic [SPACE_W-1:0] divisor,
    output logic      [QUO_W-1:0]   quotient,
    output logic                    done
);

    localparam int CNT_W = $clog2(QUO_W);

    logic [QUO_W-1:0]   quo_reg;
    logic [SPACE_W-1:0] rem_reg;
    logic [SPACE_W-1:0] dvs_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [SPACE_W:0]   shifted;
    logic [SPACE_W+1:0] trial;

    assign shifted = {rem_reg, quo_reg[QUO_W-1]};
    assign trial   = {1'b0, shifted} - {2'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(QUO_W - 1);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= {dividend, FRAC_W'(0)};
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (!trial[SPACE_W+1]) begin
                rem_reg <= trial[SPACE_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[SPACE_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

/* hdl/gcli_dp.sv */
// Datapath: configuration, located state, shared multiplier, divider and result register.
`default_nettype none

module gcli_dp import gcli_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic signed [COORD_W-1:0] s_coord_x,
    input  wire logic signed [COORD_W-1:0] s_coord_y,
    input  wire logic                  s_owned_here,
    input  wire logic [CORNERS-1:0]    s_corner_defined,
    input  wire logic signed [VALUE_W-1:0] s_corner_value_0,
    input  wire logic signed [VALUE_W-1:0] s_corner_value_1,
    input  wire logic signed [VALUE_W-1:0] s_corner_value_2,
    input  wire logic signed [VALUE_W-1:0] s_corner_value_3,
    input  wire logic [CORNERS-1:0]    s_corner_null,
    input  wire gcli_cmd_t             cmd,
    output gcli_sts_t                  sts,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_inside_domain,
    output logic                       m_point_exists,
    output logic [CELL_W-1:0]          m_cell_x,
    output logic [CELL_W-1:0]          m_cell_y,
    output logic                       m_step_x,
    output logic                       m_step_y,
    output logic signed [VALUE_W-1:0]  m_interp_value,
    output logic                       m_interp_null
);

    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int IDX_W = $clog2(MAX_NODES);

    // Configuration registers
    logic signed [COORD_W-1:0] origin_x_reg, origin_y_reg;
    logic [SPACE_W-1:0]        space_x_reg, space_y_reg;
    logic [COUNT_W-1:0]        count_x_reg, count_y_reg;

    // Located state
    logic [CELL_W-1:0] cell_x_reg, cell_y_reg;
    logic              step_x_reg, step_y_reg;
    logic [FRAC_W-1:0] frac_x_reg, frac_y_reg;
    logic [WGT_W-1:0]  weight_reg [CORNERS];
    logic              within_reg, exists_reg;

    // Working registers
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic                      okx_reg;
    logic signed [VALUE_W-1:0] val_reg [CORNERS];
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [VALUE_W-1:0] res_value_reg;
    logic                      res_null_reg;

    // Result register
    logic                      m_valid_reg;
    logic                      m_inside_reg, m_exists_reg;
    logic [CELL_W-1:0]         m_cell_x_reg, m_cell_y_reg;
    logic                      m_step_x_reg, m_step_y_reg;
    logic signed [VALUE_W-1:0] m_value_reg;
    logic                      m_null_reg;

    logic [SPACE_W-1:0] spx_eff, spy_eff;
    logic [CNT_W-1:0]   nx_eff, ny_eff;
    logic [IDX_W-1:0]   nxm1, nym1;
    logic [31:0]        ncx_w, ncy_w;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic [WGT_W-1:0]       fx, fy, gx, gy, wa, wb;

    logic [QUO_W-1:0]   div_q;
    logic               div_done;
    logic [COORD_W-1:0] div_dvd;
    logic [SPACE_W-1:0] div_dvs;
    logic [IDX_W-1:0]   div_nm1;

    logic signed [ACC_W-1:0] rnd_sum;
    logic signed [ACC_W-1:0] rnd_shift;
    logic signed [VALUE_W-1:0] sat_value;

    function automatic logic ext_ok(input logic [DIFF_W-1:0] d,
                                    input logic [PROD_W-1:0] lim);
        return !d[DIFF_W-1] && ({{(PROD_W-DIFF_W){1'b0}}, d} <= lim);
    endfunction

    // Effective spacing and node counts
    assign spx_eff = (space_x_reg == '0) ? SPACE_W'(1) : space_x_reg;
    assign spy_eff = (space_y_reg == '0) ? SPACE_W'(1) : space_y_reg;
    assign ncx_w   = 32'(count_x_reg);
    assign ncy_w   = 32'(count_y_reg);

    always_comb begin
        if (ncx_w < 32'd2)                nx_eff = CNT_W'(2);
        else if (ncx_w > 32'(MAX_NODES))  nx_eff = CNT_W'(MAX_NODES);
        else                              nx_eff = ncx_w[CNT_W-1:0];
        if (ncy_w < 32'd2)                ny_eff = CNT_W'(2);
        else if (ncy_w > 32'(MAX_NODES))  ny_eff = CNT_W'(MAX_NODES);
        else                              ny_eff = ncy_w[CNT_W-1:0];
    end

    assign nxm1 = IDX_W'(nx_eff - CNT_W'(1));
    assign nym1 = IDX_W'(ny_eff - CNT_W'(1));

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            space_x_reg  <= SPACE_W'(256);
            space_y_reg  <= SPACE_W'(256);
            count_x_reg  <= COUNT_W'(2);
            count_y_reg  <= COUNT_W'(2);
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ORIGIN_X: origin_x_reg <= cfg_wdata;
                CFG_ORIGIN_Y: origin_y_reg <= cfg_wdata;
                CFG_SPACE_X:  space_x_reg  <= cfg_wdata[SPACE_W-1:0];
                CFG_SPACE_Y:  space_y_reg  <= cfg_wdata[SPACE_W-1:0];
                CFG_COUNT_X:  count_x_reg  <= cfg_wdata[COUNT_W-1:0];
                CFG_COUNT_Y:  count_y_reg  <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Shared multiplier operands
    assign fx = {1'b0, frac_x_reg};
    assign fy = {1'b0, frac_y_reg};
    assign gx = ONE_Q16 - fx;
    assign gy = ONE_Q16 - fy;

    always_comb begin
        case (cmd.mul_idx)
            2'd0:    begin wa = gx; wb = gy; end
            2'd1:    begin wa = fx; wb = gy; end
            2'd2:    begin wa = fx; wb = fy; end
            default: begin wa = gx; wb = fy; end
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MS_EXT_X: begin
                mul_a = MA_W'(spx_eff);
                mul_b = MB_W'(nxm1);
            end
            MS_EXT_Y: begin
                mul_a = MA_W'(spy_eff);
                mul_b = MB_W'(nym1);
            end
            MS_WGT: begin
                mul_a = MA_W'(wa);
                mul_b = MB_W'(wb);
            end
            MS_VAL: begin
                mul_a = {val_reg[cmd.mul_idx][VALUE_W-1], val_reg[cmd.mul_idx]};
                mul_b = {1'b0, weight_reg[cmd.mul_idx]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_sel != MS_IDLE) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // Divider, shared by both axes
    assign div_dvd = cmd.div_axis_y ? dy_reg[COORD_W-1:0] : dx_reg[COORD_W-1:0];
    assign div_dvs = cmd.div_axis_y ? spy_eff : spx_eff;
    assign div_nm1 = cmd.div_axis_y ? nym1 : nxm1;

    gcli_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .done     (div_done)
    );

    // Capture of the request and working values
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            dx_reg     <= {s_coord_x[COORD_W-1], s_coord_x} -
                          {origin_x_reg[COORD_W-1], origin_x_reg};
            dy_reg     <= {s_coord_y[COORD_W-1], s_coord_y} -
                          {origin_y_reg[COORD_W-1], origin_y_reg};
            val_reg[0] <= s_corner_value_0;
            val_reg[1] <= s_corner_value_1;
            val_reg[2] <= s_corner_value_2;
            val_reg[3] <= s_corner_value_3;
        end
        if (cmd.chk_x) begin
            okx_reg <= ext_ok(dx_reg, prod_reg);
        end
    end

    // Rounding to nearest, ties up, then saturation
    assign rnd_sum   = acc_reg + ROUND_HALF;
    assign rnd_shift = rnd_sum >>> FRAC_W;

    always_comb begin
        if (rnd_shift[ACC_W-1:VALUE_W-1] == '0 || rnd_shift[ACC_W-1:VALUE_W-1] == '1) begin
            sat_value = rnd_shift[VALUE_W-1:0];
        end else if (rnd_shift[ACC_W-1]) begin
            sat_value = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            sat_value = {1'b0, {(VALUE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            acc_reg <= '0;
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        if (cmd.capture) begin
            res_value_reg <= '0;
            res_null_reg  <= cmd.set_null;
        end else if (cmd.fin) begin
            res_value_reg <= sat_value;
        end
        if (cmd.div_store) begin
            if (cmd.div_axis_y) frac_y_reg <= div_q[FRAC_W-1:0];
            else                frac_x_reg <= div_q[FRAC_W-1:0];
        end
    end

    // Located state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            within_reg <= 1'b0;
            exists_reg <= 1'b0;
            cell_x_reg <= '0;
            cell_y_reg <= '0;
            step_x_reg <= 1'b0;
            step_y_reg <= 1'b0;
            for (int k = 0; k < CORNERS; k++) weight_reg[k] <= '0;
        end else begin
            if (cmd.qualify) begin
                exists_reg <= within_reg && s_owned_here && (&s_corner_defined);
            end
            if (cmd.chk_xy) begin
                within_reg <= sts.loc_ok;
                exists_reg <= 1'b0;
            end
            if (cmd.div_store) begin
                if (cmd.div_axis_y) begin
                    cell_y_reg <= div_q[FRAC_W +: CELL_W];
                    step_y_reg <= (div_q[QUO_W-1:FRAC_W] != COORD_W'(div_nm1));
                end else begin
                    cell_x_reg <= div_q[FRAC_W +: CELL_W];
                    step_x_reg <= (div_q[QUO_W-1:FRAC_W] != COORD_W'(div_nm1));
                end
            end
            if (cmd.wgt_wr) begin
                weight_reg[cmd.wgt_idx] <= WGT_W'((prod_reg[33:0] + 34'd32768) >> FRAC_W);
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_inside_reg <= within_reg;
            m_exists_reg <= exists_reg;
            m_cell_x_reg <= cell_x_reg;
            m_cell_y_reg <= cell_y_reg;
            m_step_x_reg <= step_x_reg;
            m_step_y_reg <= step_y_reg;
            m_value_reg  <= res_value_reg;
            m_null_reg   <= res_null_reg;
        end
    end

    assign sts.loc_ok   = okx_reg && ext_ok(dy_reg, prod_reg);
    assign sts.null_now = !exists_reg || (s_corner_null != '0);
    assign sts.div_done = div_done;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_inside_domain = m_inside_reg;
    assign m_point_exists  = m_exists_reg;
    assign m_cell_x        = m_cell_x_reg;
    assign m_cell_y        = m_cell_y_reg;
    assign m_step_x        = m_step_x_reg;
    assign m_step_y        = m_step_y_reg;
    assign m_interp_value  = m_value_reg;
    assign m_interp_null   = m_null_reg;

`ifndef SYNTH
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while occupied");

    a_null_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_null_reg) |-> (m_value_reg == '0))
        else $error("null result carries a nonzero value");

    a_exists_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        exists_reg |-> within_reg)
        else $error("point exists without lying inside the grid");

    a_wgt_located: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wgt_wr |-> within_reg)
        else $error("weights written for a point outside the grid");
`endif

endmodule

`default_nettype wire

/* hdl/gcli_ctrl.sv */
// Controller: sequences locate, qualify and interpolate requests over the datapath.
`default_nettype none

module gcli_ctrl import gcli_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic [ACTION_W-1:0] s_action,
    output logic                     s_ready,
    input  wire gcli_sts_t           sts,
    output gcli_cmd_t                cmd
);

    state_t         state_reg, state_next;
    logic [K_W-1:0] k_reg, k_next;
    logic           k_last;

    assign k_last = (k_reg == K_W'(CORNERS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            S_IDLE: begin
                k_next = '0;
                if (s_valid) begin
                    unique case (action_t'(s_action))
                        ACT_LOCATE:  state_next = S_EXT_X;
                        ACT_QUALIFY: state_next = S_DONE;
                        ACT_INTERP:  state_next = sts.null_now ? S_DONE : S_ACC;
                        ACT_NOP:     state_next = S_DONE;
                    endcase
                end
            end
            S_EXT_X:     state_next = S_EXT_Y;
            S_EXT_Y:     state_next = S_CHK;
            S_CHK:       state_next = sts.loc_ok ? S_DIVX_GO : S_DONE;
            S_DIVX_GO:   state_next = S_DIVX_WAIT;
            S_DIVX_WAIT: if (sts.div_done) state_next = S_DIVY_GO;
            S_DIVY_GO:   state_next = S_DIVY_WAIT;
            S_DIVY_WAIT: begin
                k_next = '0;
                if (sts.div_done) state_next = S_WGT;
            end
            S_WGT: begin
                if (k_last) state_next = S_DONE;
                else        k_next = k_reg + 1'b1;
            end
            S_ACC: begin
                if (k_last) state_next = S_FIN;
                else        k_next = k_reg + 1'b1;
            end
            S_FIN:       state_next = S_DONE;
            S_DONE:      if (sts.out_free) state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd         = '0;
        cmd.mul_sel = MS_IDLE;
        cmd.mul_idx = k_reg[CIDX_W-1:0];
        cmd.wgt_idx = CIDX_W'(k_reg - 1'b1);
        s_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture  = 1'b1;
                    cmd.qualify  = (action_t'(s_action) == ACT_QUALIFY);
                    cmd.set_null = (action_t'(s_action) == ACT_INTERP) && sts.null_now;
                end
            end
            S_EXT_X: cmd.mul_sel = MS_EXT_X;
            S_EXT_Y: begin
                cmd.mul_sel = MS_EXT_Y;
                cmd.chk_x   = 1'b1;
            end
            S_CHK:   cmd.chk_xy = 1'b1;
            S_DIVX_GO: cmd.div_start = 1'b1;
            S_DIVX_WAIT: cmd.div_store = sts.div_done;
            S_DIVY_GO: begin
                cmd.div_start  = 1'b1;
                cmd.div_axis_y = 1'b1;
            end
            S_DIVY_WAIT: begin
                cmd.div_axis_y = 1'b1;
                cmd.div_store  = sts.div_done;
            end
            S_WGT: begin
                cmd.mul_sel = k_last ? MS_IDLE : MS_WGT;
                cmd.wgt_wr  = (k_reg != '0);
            end
            S_ACC: begin
                cmd.mul_sel = k_last ? MS_IDLE : MS_VAL;
                cmd.acc_add = (k_reg != '0);
            end
            S_FIN:   cmd.fin = 1'b1;
            S_DONE:  cmd.out_load = sts.out_free;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/grid_cell_locate_bilinear_interp_unit.sv */
// Top level of the regular-grid cell locate and bilinear interpolation unit.
`default_nettype none

// One request at a time enters on the s_ channel and gives exactly one result on
// the m_ channel, held in an output register so the next request is taken while
// the result waits. Locate subtracts the origin, checks each axis against the
// extent up to the last node with the shared multiplier, then runs one restoring
// divider, one quotient bit per cycle over 48 bits, per axis (x then y) to get
// the cell index and the Q0.16 fraction in one quotient, and forms the four
// weights with the shared multiplier. Qualify updates the exists flag at acceptance.
// Interpolate pushes the four corner products through the one 33x18 multiplier
// into an accumulator, rounds and saturates.
// Configuration (origin, spacing, node counts) is written through cfg_wr_en,
// cfg_index and cfg_wdata; the user must do so only while no request is in
// flight, as the block itself does not enforce it.
module grid_cell_locate_bilinear_interp_unit import gcli_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [ACTION_W-1:0]       s_action,
    input  wire logic signed [COORD_W-1:0] s_coord_x,
    input  wire logic signed [COORD_W-1:0] s_coord_y,
    input  wire logic                      s_owned_here,
    input  wire logic [CORNERS-1:0]        s_corner_defined,
    input  wire logic signed [VALUE_W-1:0] s_corner_value_0,
    input  wire logic signed [VALUE_W-1:0] s_corner_value_1,
    input  wire logic signed [VALUE_W-1:0] s_corner_value_2,
    input  wire logic signed [VALUE_W-1:0] s_corner_value_3,
    input  wire logic [CORNERS-1:0]        s_corner_null,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_inside_domain,
    output logic                           m_point_exists,
    output logic [CELL_W-1:0]              m_cell_x,
    output logic [CELL_W-1:0]              m_cell_y,
    output logic                           m_step_x,
    output logic                           m_step_y,
    output logic signed [VALUE_W-1:0]      m_interp_value,
    output logic                           m_interp_null
);

    gcli_cmd_t cmd;
    gcli_sts_t sts;

    // Sequence each request
    gcli_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold configuration and located state, do the arithmetic
    gcli_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_coord_x        (s_coord_x),
        .s_coord_y        (s_coord_y),
        .s_owned_here     (s_owned_here),
        .s_corner_defined (s_corner_defined),
        .s_corner_value_0 (s_corner_value_0),
        .s_corner_value_1 (s_corner_value_1),
        .s_corner_value_2 (s_corner_value_2),
        .s_corner_value_3 (s_corner_value_3),
        .s_corner_null    (s_corner_null),
        .cmd              (cmd),
        .sts              (sts),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_inside_domain  (m_inside_domain),
        .m_point_exists   (m_point_exists),
        .m_cell_x         (m_cell_x),
        .m_cell_y         (m_cell_y),
        .m_step_x         (m_step_x),
        .m_step_y         (m_step_y),
        .m_interp_value   (m_interp_value),
        .m_interp_null    (m_interp_null)
    );

endmodule

`default_nettype wire
